// ===== sv/sle_pkg.sv =====
// Shared types and constants for the serial line editor.
// Used by sle_ctrl, sle_dp and serial_line_editor_unit; depends on nothing.
package sle_pkg;

  // Default number of entries in the line store.
  localparam int unsigned LineBufDepthDef = 64;

  // Byte codes with a special meaning.
  localparam logic [7:0] KEY_DELETE = 8'd127;
  localparam logic [7:0] KEY_BELL   = 8'd7;
  localparam logic [7:0] KEY_LF     = 8'd10;
  localparam logic [7:0] KEY_CR     = 8'd13;

  // Result kinds.
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_BELL = 2'd1;
  localparam logic [1:0] KIND_LINE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       out_load;     // load the result register
    logic [1:0] out_kind;     // kind of the loaded result
    logic       wr_en;        // store the received byte and count it
    logic       fill_dec;     // drop the last held character
    logic       fill_clr;     // empty the store
    logic       drain_start;  // latch the line length and point at entry zero
    logic       drain_step;   // advance to the next line character
  } sle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // the result register can take a new result
    logic fill_empty;  // no character is held
    logic fill_full;   // the fill count has reached one below the store depth
    logic byte_del;    // received byte is a delete
    logic byte_term;   // received byte is CR or LF
    logic drain_last;  // current line character is the final one
  } sle_sts_t;

endpackage

// ===== sv/sle_ctrl.sv =====
// Controller state machine of the serial line editor.
// Depends on sle_pkg for the command and status structs.
module sle_ctrl import sle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sle_sts_t sts_i,
  output sle_cmd_t cmd_o
);

  localparam logic StIdle  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic state_q, state_d;
  logic accept;

  // A byte is taken only while idle and the result register has room.
  assign in_stall_o = !((state_q == StIdle) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Decide the commands for this cycle and the next state.
  always_comb begin
    cmd_o          = '0;
    cmd_o.out_kind = KIND_ECHO;
    state_d        = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (sts_i.byte_del) begin
            if (!sts_i.fill_empty) begin
              cmd_o.fill_dec = 1'b1;
              cmd_o.out_load = 1'b1;
              cmd_o.out_kind = KIND_ECHO;
            end
          end else if (sts_i.fill_full) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = KIND_BELL;
          end else begin
            cmd_o.wr_en    = 1'b1;
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = KIND_ECHO;
            if (sts_i.byte_term) begin
              cmd_o.fill_clr = 1'b1;
              if (!sts_i.fill_empty) begin
                cmd_o.drain_start = 1'b1;
                state_d           = StDrain;
              end
            end
          end
        end
      end
      StDrain: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_LINE;
          if (sts_i.drain_last) begin
            state_d = StIdle;
          end else begin
            cmd_o.drain_step = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/sle_dp.sv =====
// Datapath of the serial line editor: line store, fill count, drain pointer
// and result register. Depends on sle_pkg.
module sle_dp import sle_pkg::*; #(
  parameter int unsigned LINE_BUF_DEPTH = LineBufDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       out_stall_i,
  input  sle_cmd_t   cmd_i,
  output sle_sts_t   sts_o,
  output logic       out_valid_o,
  output logic [1:0] kind_o,
  output logic [7:0] value_o,
  output logic       last_o
);

  localparam int unsigned AddrW = $clog2(LINE_BUF_DEPTH);
  localparam int unsigned FillW = AddrW + 1;
  localparam logic [FillW-1:0] FillMax = FillW'(LINE_BUF_DEPTH - 1);

  logic [7:0]       mem [LINE_BUF_DEPTH];
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] len_q;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [7:0]       rd_data_q;
  logic             out_valid_q;
  logic [1:0]       kind_q;
  logic [7:0]       value_q;
  logic             last_q;
  logic [7:0]       value_d;

  // Status toward the controller.
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.fill_empty = (fill_q == '0);
  assign sts_o.fill_full  = (fill_q >= FillMax);
  assign sts_o.byte_del   = (rx_byte_i == KEY_DELETE);
  assign sts_o.byte_term  = (rx_byte_i == KEY_CR) || (rx_byte_i == KEY_LF);
  assign sts_o.drain_last = ({1'b0, rd_ptr_q} + FillW'(1)) == len_q;

  // Fill count: clearing wins over storing, storing over deleting.
  always_comb begin
    fill_d = fill_q;
    if (cmd_i.fill_clr) begin
      fill_d = '0;
    end else if (cmd_i.wr_en) begin
      fill_d = fill_q + FillW'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  // Drain pointer; the store is read at its next value so that the read
  // data is ready one line character per cycle while the output does not stall.
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    if (cmd_i.drain_start) begin
      rd_ptr_d = '0;
    end else if (cmd_i.drain_step) begin
      rd_ptr_d = rd_ptr_q + AddrW'(1);
    end
  end

  // Line store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[fill_q[AddrW-1:0]] <= rx_byte_i;
    end
    rd_data_q <= mem[rd_ptr_d];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      rd_ptr_q <= rd_ptr_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result value selection.
  always_comb begin
    case (cmd_i.out_kind)
      KIND_ECHO: value_d = rx_byte_i;
      KIND_BELL: value_d = KEY_BELL;
      KIND_LINE: value_d = rd_data_q;
      default:   value_d = rx_byte_i;
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.drain_start) begin
      len_q <= fill_q;
    end
    if (cmd_i.out_load) begin
      kind_q  <= cmd_i.out_kind;
      value_q <= value_d;
      last_q  <= (cmd_i.out_kind == KIND_LINE) && sts_o.drain_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule

// ===== sv/serial_line_editor_unit.sv =====
// Serial line editor: one received byte in, one echo or bell out (none for a
// delete on an empty line); a terminator sends the line one per cycle while not stalled, the last marked.
// Latency: a result is shown the cycle after its byte is accepted.
// Throughput: one byte per cycle when no line ends and the output does not
// stall; a terminator holds off input while the single store read port drains the line.
// Reset: asynchronous, clears fill count, drain pointer, state, valid flag.
module serial_line_editor_unit import sle_pkg::*; #(
  parameter int unsigned LINE_BUF_DEPTH = LineBufDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] value_o,
  output logic       last_o
);

  sle_cmd_t cmd;
  sle_sts_t sts;

  // Sequencing of each request.
  sle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and result register.
  sle_dp #(
    .LINE_BUF_DEPTH (LINE_BUF_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_byte_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

endmodule
